/* hdl/skuc_pkg.sv */
// Shared types and constants for the sorted key usage counter.
// No dependencies.
package skuc_pkg;

  localparam int unsigned TableDepthDefault = 2048;
  localparam int unsigned KeyBytesDefault   = 15;
  localparam int unsigned HeadW  = 64;
  localparam int unsigned TailW  = 56;
  localparam int unsigned KeyW   = HeadW + TailW;
  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic {
    FuncAdd   = 1'b0,
    FuncQuery = 1'b1
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [HeadW-1:0] key_head;
    logic [TailW-1:0] key_tail;
  } req_t;

  typedef struct packed {
    logic [CountW-1:0] use_count;
    logic              was_present;
    logic              dropped_full;
  } rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StProbe,
    StCompare,
    StShiftRead,
    StShiftWrite,
    StFinish
  } state_e;

  // Zeroes every byte after the first zero byte and every byte at or past key_bytes.
  function automatic logic [KeyW-1:0] normalize_key(logic [KeyW-1:0] k, int unsigned key_bytes);
    logic [KeyW-1:0] r;
    logic            ended;
    r     = k;
    ended = 1'b0;
    for (int i = 0; i < KeyW / 8; i++) begin
      if (i >= key_bytes || k[KeyW-1-8*i -: 8] == 8'd0) ended = 1'b1;
      if (ended) r[KeyW-1-8*i -: 8] = 8'd0;
    end
    return r;
  endfunction

endpackage

/* hdl/skuc_mem.sv */
// Entry memory of the sorted key usage counter: key and count per entry.
// Depends on skuc_pkg.
module skuc_mem #(
  parameter int unsigned TableDepth = skuc_pkg::TableDepthDefault,
  localparam int unsigned AddrW = $clog2(TableDepth),
  localparam int unsigned EntW  = skuc_pkg::KeyW + skuc_pkg::CountW
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [EntW-1:0]  rdata_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [EntW-1:0]  wdata_i
);

  logic [EntW-1:0] mem [TableDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/skuc_ctrl.sv */
// Search, update and insert sequencer of the sorted key usage counter.
// Depends on skuc_pkg; drives the ports of skuc_mem.
module skuc_ctrl #(
  parameter int unsigned TableDepth = skuc_pkg::TableDepthDefault,
  parameter int unsigned KeyBytes   = skuc_pkg::KeyBytesDefault,
  localparam int unsigned AddrW = $clog2(TableDepth),
  localparam int unsigned CntW  = $clog2(TableDepth + 1),
  localparam int unsigned EntW  = skuc_pkg::KeyW + skuc_pkg::CountW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  skuc_pkg::req_t    req_i,
  output logic              busy_o,
  output logic              done_o,
  output skuc_pkg::rsp_t    rsp_o,
  output logic [AddrW-1:0]  raddr_o,
  input  logic [EntW-1:0]   rdata_i,
  output logic              we_o,
  output logic [AddrW-1:0]  waddr_o,
  output logic [EntW-1:0]   wdata_o
);

  localparam int unsigned KeyW   = skuc_pkg::KeyW;
  localparam int unsigned CountW = skuc_pkg::CountW;

  skuc_pkg::state_e state_q, state_d;
  logic [CntW-1:0]   lo_q, lo_d, hi_q, hi_d, used_q, used_d, idx_q, idx_d;
  logic [KeyW-1:0]   key_q, key_d;
  skuc_pkg::func_e   func_q, func_d;
  logic [EntW-1:0]   hold_q, hold_d;
  logic              done_q, done_d;
  skuc_pkg::rsp_t    rsp_q, rsp_d;
  logic [CntW-1:0]   mid;
  logic [KeyW-1:0]   ent_key;
  logic [CountW-1:0] ent_cnt;

  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign ent_key = rdata_i[EntW-1 -: KeyW];
  assign ent_cnt = rdata_i[CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skuc_pkg::StIdle;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    idx_q  <= idx_d;
    key_q  <= key_d;
    func_q <= func_d;
    hold_q <= hold_d;
    rsp_q  <= rsp_d;
  end

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    used_d  = used_q;
    idx_d   = idx_q;
    key_d   = key_q;
    func_d  = func_q;
    hold_d  = hold_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    raddr_o = mid[AddrW-1:0];
    we_o    = 1'b0;
    waddr_o = idx_q[AddrW-1:0];
    wdata_o = hold_q;
    unique case (state_q)
      skuc_pkg::StIdle: begin
        if (start_i) begin
          key_d   = skuc_pkg::normalize_key({req_i.key_head, req_i.key_tail}, KeyBytes);
          func_d  = req_i.func;
          lo_d    = '0;
          hi_d    = used_q;
          state_d = skuc_pkg::StProbe;
        end
      end
      skuc_pkg::StProbe: begin
        if (lo_q < hi_q) begin
          state_d = skuc_pkg::StCompare;
        end else begin
          rsp_d = '0;
          if (func_q == skuc_pkg::FuncQuery) begin
            state_d = skuc_pkg::StFinish;
          end else if (used_q == CntW'(TableDepth)) begin
            rsp_d.dropped_full = 1'b1;
            state_d = skuc_pkg::StFinish;
          end else begin
            rsp_d.use_count = CountW'(1);
            idx_d   = used_q;
            state_d = (used_q == lo_q) ? skuc_pkg::StShiftWrite : skuc_pkg::StShiftRead;
            hold_d  = {key_q, CountW'(1)};
          end
        end
      end
      skuc_pkg::StCompare: begin
        if (ent_key == key_q) begin
          rsp_d.was_present  = 1'b1;
          rsp_d.dropped_full = 1'b0;
          rsp_d.use_count    = ent_cnt;
          if (func_q == skuc_pkg::FuncAdd && ent_cnt != skuc_pkg::CountMax) begin
            rsp_d.use_count = ent_cnt + CountW'(1);
            we_o    = 1'b1;
            waddr_o = mid[AddrW-1:0];
            wdata_o = {key_q, ent_cnt + CountW'(1)};
          end
          state_d = skuc_pkg::StFinish;
        end else begin
          if (ent_key < key_q) lo_d = mid + CntW'(1);
          else hi_d = mid;
          state_d = skuc_pkg::StProbe;
        end
      end
      skuc_pkg::StShiftRead: begin
        raddr_o = AddrW'(idx_q - CntW'(1));
        state_d = skuc_pkg::StShiftWrite;
      end
      skuc_pkg::StShiftWrite: begin
        we_o = 1'b1;
        if (idx_q == lo_q) begin
          wdata_o = {key_q, CountW'(1)};
          used_d  = used_q + CntW'(1);
          state_d = skuc_pkg::StFinish;
        end else begin
          wdata_o = rdata_i;
          idx_d   = idx_q - CntW'(1);
          state_d = (idx_q - CntW'(1) == lo_q) ? skuc_pkg::StShiftWrite
                                                 : skuc_pkg::StShiftRead;
        end
      end
      skuc_pkg::StFinish: begin
        done_d  = 1'b1;
        state_d = skuc_pkg::StIdle;
      end
      default: state_d = skuc_pkg::StIdle;
    endcase
  end

  assign busy_o = (state_q != skuc_pkg::StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* hdl/sorted_key_usage_counter_top.sv */
// Top level of the sorted key usage counter: sequencer plus entry memory.
// Depends on skuc_pkg, skuc_ctrl and skuc_mem.
//
// One word is taken when start is high and busy is low. Its result shows for
// one cycle with done_o. The receiver cannot stall, so it must take the result
// in that cycle. Each item is a sequence of binary search
// probes (about log2 of the entries in use, 12 at most for 2048 entries),
// each probe a memory read and a compare. An add of a new key then moves
// every higher entry up one place, a read and a write per moved entry
// through the single memory port pair.
module sorted_key_usage_counter_top #(
  parameter int unsigned TableDepth = skuc_pkg::TableDepthDefault,
  parameter int unsigned KeyBytes   = skuc_pkg::KeyBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  skuc_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output skuc_pkg::rsp_t rsp_o
);

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned EntW  = skuc_pkg::KeyW + skuc_pkg::CountW;

  logic [AddrW-1:0] raddr, waddr;
  logic [EntW-1:0]  rdata, wdata;
  logic             we;

  skuc_ctrl #(.TableDepth(TableDepth), .KeyBytes(KeyBytes)) u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .req_i, .busy_o(busy), .done_o, .rsp_o,
    .raddr_o(raddr), .rdata_i(rdata), .we_o(we), .waddr_o(waddr), .wdata_o(wdata)
  );

  skuc_mem #(.TableDepth(TableDepth)) u_mem (
    .clk_i, .raddr_i(raddr), .rdata_o(rdata), .we_i(we), .waddr_i(waddr), .wdata_i(wdata)
  );

endmodule

/* hdl/skuc_checker.sv */
// Port checker for the sorted key usage counter, bound to the top level.
// Depends on skuc_pkg.
module skuc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input skuc_pkg::rsp_t rsp_o
);

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.was_present && rsp_o.dropped_full))
    else $error("present and dropped together");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.dropped_full |-> rsp_o.use_count == '0)
    else $error("dropped word reports a count");

  a_present_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.was_present |-> rsp_o.use_count != '0)
    else $error("present key with zero count");

endmodule

bind sorted_key_usage_counter_top skuc_checker u_skuc_checker (.*);
